### design/hse_pkg.sv
// Shared constants, codes and types of the Huffman stream encoder.
package hse_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOLS      = 257;
    localparam int END_SYMBOL   = 256;

    localparam int ACT_W  = 2;
    localparam int SYM_W  = 9;
    localparam int BITS_W = 32;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    localparam int TBL_IDX_W = $clog2(SYMBOLS);
    localparam int ELEN_W    = $clog2(MAX_CODE_LEN + 1);
    localparam int WORK_W    = MAX_CODE_LEN + BYTE_W;
    localparam int NB_W      = $clog2(WORK_W);

    localparam int QPTR_W = 2;
    localparam int QDEPTH = 2 ** QPTR_W;
    localparam int QCNT_W = QPTR_W + 1;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FINISH = 2'd2
    } t_action;

    typedef struct packed {
        logic [MAX_CODE_LEN-1:0] code;
        logic [ELEN_W-1:0]       len;
    } t_entry;

    // code is left-aligned: first bit in the top position
    typedef struct packed {
        logic [MAX_CODE_LEN-1:0] code;
        logic [ELEN_W-1:0]       len;
        logic                    fin;
    } t_job;

endpackage

### design/hse_if.sv
// Stream interfaces of the encoder: input word channel and output byte channel.
interface hse_in_if import hse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [SYM_W-1:0]  symbol;
    logic [BITS_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, action, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

interface hse_out_if import hse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              stream_end;

    modport source (output valid, out_byte, last, stream_end, input ready);
    modport sink   (input valid, out_byte, last, stream_end, output ready);
endinterface

### design/hse_front.sv
// Front end: accepts words, keeps the code table, looks up codes and issues jobs.
module hse_front import hse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hse_in_if.sink            i_item,
    input  logic [QCNT_W-1:0] i_q_cnt,
    output logic              o_push,
    output t_job              o_job
);

    t_entry               r_tbl [SYMBOLS];
    logic [SYMBOLS-1:0]   r_vld;
    t_entry               r_rd;
    logic                 r_s1_valid;
    logic                 r_s1_fin;
    logic                 r_s1_hit;

    logic                 w_accept;
    logic                 w_is_load;
    logic                 w_is_lookup;
    logic [SYM_W-1:0]     w_addr;
    logic                 w_in_range;
    logic [TBL_IDX_W-1:0] w_idx;
    t_entry               w_wr;
    logic [ELEN_W-1:0]    w_len;

    // room for this word plus the one still in the lookup stage
    assign i_item.ready = ((QCNT_W + 1)'(i_q_cnt) + (QCNT_W + 1)'(r_s1_valid))
                          < (QCNT_W + 1)'(QDEPTH);
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_is_load    = (i_item.action == ACT_LOAD);
    assign w_is_lookup  = (i_item.action == ACT_ENCODE) || (i_item.action == ACT_FINISH);

    assign w_addr     = (i_item.action == ACT_FINISH) ? SYM_W'(END_SYMBOL) : i_item.symbol;
    assign w_in_range = {1'b0, w_addr} < (SYM_W + 1)'(SYMBOLS);
    assign w_idx      = w_addr[TBL_IDX_W-1:0];

    always_comb begin
        w_wr.code = MAX_CODE_LEN'(i_item.code_bits);
        if (int'(i_item.code_length) > MAX_CODE_LEN) begin
            w_wr.len = ELEN_W'(MAX_CODE_LEN);
        end else begin
            w_wr.len = ELEN_W'(i_item.code_length);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_load && w_in_range) begin
            r_tbl[w_idx] <= w_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_tbl[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_fin   <= 1'b0;
            r_s1_hit   <= 1'b0;
        end else begin
            if (w_accept && w_is_load && w_in_range) begin
                r_vld[w_idx] <= 1'b1;
            end
            r_s1_valid <= w_accept && w_is_lookup;
            r_s1_fin   <= (i_item.action == ACT_FINISH);
            r_s1_hit   <= w_in_range && r_vld[w_idx];
        end
    end

    // unloaded or out-of-table symbol behaves as a zero-length code
    assign w_len      = r_s1_hit ? r_rd.len : '0;
    assign o_push     = r_s1_valid;
    assign o_job.len  = w_len;
    assign o_job.fin  = r_s1_fin;
    assign o_job.code = r_rd.code << (ELEN_W'(MAX_CODE_LEN) - w_len);

endmodule

### design/hse_queue.sv
// Short job queue between lookup front end and bit packer.
module hse_queue import hse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_job              i_job,
    input  logic              i_pop,
    output logic              o_valid,
    output t_job              o_job,
    output logic [QCNT_W-1:0] o_cnt
);

    t_job              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rd_ptr];
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < QCNT_W'(QDEPTH)) || i_pop)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("job queue underflow");

endmodule

### design/hse_back.sv
// Bit packer: merges codes into the accumulator and drains whole bytes, padding the last one on a finish.
module hse_back import hse_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_job_valid,
    input  t_job     i_job,
    output logic     o_pop,
    hse_out_if.source o_res
);

    logic [WORK_W-1:0] r_work;
    logic [NB_W-1:0]   r_nbits;
    logic              r_fin;
    logic [WORK_W-1:0] n_work;
    logic [NB_W-1:0]   n_nbits;
    logic              n_fin;

    logic              w_out_valid;
    logic              w_out_take;
    logic [WORK_W-1:0] w_code_al;

    // a byte is ready when 8 bits are pending, or any bits on a finish (padded)
    assign w_out_valid = (r_nbits >= NB_W'(BYTE_W)) || (r_fin && (r_nbits != '0));
    assign w_out_take  = w_out_valid && o_res.ready;
    assign o_pop       = i_job_valid && !w_out_valid;

    assign w_code_al = {i_job.code, BYTE_W'(0)} >> r_nbits[2:0];

    always_comb begin
        n_work  = r_work;
        n_nbits = r_nbits;
        n_fin   = r_fin;
        if (o_pop) begin
            n_work  = r_work | w_code_al;
            n_nbits = r_nbits + NB_W'(i_job.len);
            n_fin   = i_job.fin;
        end else if (w_out_take) begin
            n_work = r_work << BYTE_W;
            if (r_nbits >= NB_W'(BYTE_W)) begin
                n_nbits = r_nbits - NB_W'(BYTE_W);
            end else begin
                n_nbits = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work  <= '0;
            r_nbits <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_work  <= n_work;
            r_nbits <= n_nbits;
            r_fin   <= n_fin;
        end
    end

    assign o_res.valid      = w_out_valid;
    assign o_res.out_byte   = r_work[WORK_W-1 -: BYTE_W];
    assign o_res.last       = r_fin ? (r_nbits <= NB_W'(BYTE_W))
                                    : (r_nbits < NB_W'(2 * BYTE_W));
    assign o_res.stream_end = r_fin && (r_nbits <= NB_W'(BYTE_W));

    a_nbits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_nbits) <= MAX_CODE_LEN + BYTE_W - 1)
        else $error("accumulator bit count out of range");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !o_res.last) |=> o_res.valid)
        else $error("byte run ended without last");

    a_stream_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.stream_end) |=> (r_nbits == '0))
        else $error("bits left after stream end");

endmodule

### design/huffman_stream_encoder.sv
// Huffman stream encoder top: code-table front end, job queue and bit packer.
// A word passes the lookup stage, the job queue and the packer accumulator before its first byte is valid.
// Throughput: one word per cycle while no bytes come out; a word that completes
// bytes holds the packer for one merge, then one byte per cycle while o_res.ready is high.
// Reset (i_rst_n low, synchronous): table entries read as length 0, accumulator
// and queue are cleared; no clearing pass, words are taken right after reset.
module huffman_stream_encoder import hse_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hse_in_if.sink    i_item,
    hse_out_if.source o_res
);

    logic              w_push;
    t_job              w_push_job;
    logic              w_pop;
    logic              w_q_valid;
    t_job              w_q_job;
    logic [QCNT_W-1:0] w_q_cnt;

    hse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_q_cnt (w_q_cnt),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    hse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .o_cnt   (w_q_cnt)
    );

    hse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

endmodule

### dv/tb_huffman_stream_encoder.sv
// Testbench of the Huffman stream encoder: directed table, random code streams, byte checker.
`timescale 1ns / 100ps

module tb_huffman_stream_encoder import hse_pkg::*; ();

    localparam logic [ACT_W-1:0] ACT_UNDEF = 2'd3;
    localparam int USE_MODEL    = -1;
    localparam int RAND_ITEMS   = 180;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NDIR         = 27;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SYM_W-1:0]  symbol;
        logic [BITS_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } t_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              stream_end;
    } t_byte;

    // nexp: USE_MODEL, or the count (0 or 1) of bytes typed into the row
    typedef struct packed {
        t_word w;
        int    nexp;
        t_byte r;
    } t_row;

    localparam t_byte NO_BYTE = '0;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic rx_ready = 1'b0;

    hse_in_if  word_ch ();
    hse_out_if byte_ch ();

    assign byte_ch.ready = rx_ready;

    huffman_stream_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (word_ch),
        .o_res   (byte_ch)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // code table copy and bit packer state
    logic [BITS_W-1:0] code_of [SYMBOLS];
    logic [LEN_W-1:0]  len_of  [SYMBOLS];
    logic [BYTE_W-1:0] acc_bits;
    int unsigned       acc_cnt;

    t_byte fresh_bytes [$];
    t_byte want_bytes  [$];

    int  mismatches = 0;
    int  counted = 0;
    int  cycle_cnt = 0;
    bit  calm_in = 1'b0;
    bit  calm_out = 1'b0;
    int  stall_left = 0;

    t_row dir_rows [NDIR] = '{
        '{'{ACT_ENCODE, 9'd0,   32'h0000_0000, 6'd0},  0, NO_BYTE},
        '{'{ACT_FINISH, 9'd0,   32'h0000_0000, 6'd0},  0, NO_BYTE},
        '{'{ACT_UNDEF,  9'd5,   32'hFFFF_FFFF, 6'd63}, 0, NO_BYTE},
        '{'{ACT_LOAD,   9'd65,  32'hFFFF_FFFF, 6'd8},  0, NO_BYTE},
        '{'{ACT_ENCODE, 9'd65,  32'h0000_0000, 6'd0},  1, '{8'hFF, 1'b1, 1'b0}},
        '{'{ACT_LOAD,   9'd0,   32'h0000_0000, 6'd32}, 0, NO_BYTE},
        '{'{ACT_ENCODE, 9'd0,   32'h0000_0000, 6'd0},  USE_MODEL, NO_BYTE},
        '{'{ACT_LOAD,   9'd256, 32'h0000_0001, 6'd1},  0, NO_BYTE},
        '{'{ACT_LOAD,   9'd300, 32'h0000_001F, 6'd5},  0, NO_BYTE},
        '{'{ACT_ENCODE, 9'd300, 32'h0000_0000, 6'd0},  0, NO_BYTE},
        '{'{ACT_LOAD,   9'd1,   32'h000A_BCDE, 6'd63}, 0, NO_BYTE},
        '{'{ACT_ENCODE, 9'd1,   32'h0000_0000, 6'd0},  USE_MODEL, NO_BYTE},
        '{'{ACT_LOAD,   9'd2,   32'h0000_0005, 6'd3},  0, NO_BYTE},
        '{'{ACT_ENCODE, 9'd2,   32'h0000_0000, 6'd0},  USE_MODEL, NO_BYTE},
        '{'{ACT_ENCODE, 9'd256, 32'h0000_0000, 6'd0},  USE_MODEL, NO_BYTE},
        '{'{ACT_FINISH, 9'd0,   32'h0000_0000, 6'd0},  USE_MODEL, NO_BYTE},
        '{'{ACT_LOAD,   9'd256, 32'h0000_0000, 6'd0},  0, NO_BYTE},
        '{'{ACT_ENCODE, 9'd2,   32'h0000_0000, 6'd0},  0, NO_BYTE},
        '{'{ACT_FINISH, 9'd0,   32'h0000_0000, 6'd0},  1, '{8'hA0, 1'b1, 1'b1}},
        '{'{ACT_LOAD,   9'd511, 32'hFFFF_FFFF, 6'd63}, 0, NO_BYTE},
        '{'{ACT_ENCODE, 9'd511, 32'hFFFF_FFFF, 6'd63}, 0, NO_BYTE},
        '{'{ACT_LOAD,   9'd256, 32'hDEAD_BEEF, 6'd32}, 0, NO_BYTE},
        '{'{ACT_FINISH, 9'd0,   32'h0000_0000, 6'd0},  USE_MODEL, NO_BYTE},
        '{'{ACT_LOAD,   9'd3,   32'h0000_007F, 6'd7},  0, NO_BYTE},
        '{'{ACT_ENCODE, 9'd3,   32'h0000_0000, 6'd0},  0, NO_BYTE},
        '{'{ACT_ENCODE, 9'd65,  32'h0000_0000, 6'd0},  USE_MODEL, NO_BYTE},
        '{'{ACT_FINISH, 9'd0,   32'h0000_0000, 6'd0},  USE_MODEL, NO_BYTE}
    };

    function automatic t_word make_word(input logic [ACT_W-1:0] a, input logic [SYM_W-1:0] s,
                                        input logic [BITS_W-1:0] b, input logic [LEN_W-1:0] l);
        t_word w;
        w.action      = a;
        w.symbol      = s;
        w.code_bits   = b;
        w.code_length = l;
        return w;
    endfunction

    // append a symbol's code MSB first, collecting every byte that fills up
    function automatic void append_symbol(input int unsigned sym);
        int unsigned n;
        if (sym >= SYMBOLS) return;
        n = 32'(len_of[sym]);
        while (n > 0) begin
            n--;
            acc_bits = {acc_bits[BYTE_W-2:0], code_of[sym][n]};
            acc_cnt++;
            if (acc_cnt == BYTE_W) begin
                fresh_bytes.push_back('{acc_bits, 1'b0, 1'b0});
                acc_bits = '0;
                acc_cnt  = 0;
            end
        end
    endfunction

    function automatic void flag_tail(input logic end_flag);
        t_byte tail;
        if (fresh_bytes.size() == 0) return;
        tail = fresh_bytes.pop_back();
        tail.last = 1'b1;
        tail.stream_end = end_flag;
        fresh_bytes.push_back(tail);
    endfunction

    function automatic void predict_bytes(input t_word w);
        logic [BYTE_W-1:0] padded;
        fresh_bytes.delete();
        case (w.action)
            ACT_LOAD: begin
                if (w.symbol < SYMBOLS) begin
                    code_of[w.symbol] = w.code_bits;
                    len_of[w.symbol]  = (w.code_length > MAX_CODE_LEN) ?
                                        LEN_W'(MAX_CODE_LEN) : w.code_length;
                end
            end
            ACT_ENCODE: begin
                append_symbol(32'(w.symbol));
                flag_tail(1'b0);
            end
            ACT_FINISH: begin
                append_symbol(END_SYMBOL);
                if (acc_cnt > 0) begin
                    padded = acc_bits << (BYTE_W - acc_cnt);
                    fresh_bytes.push_back('{padded, 1'b0, 1'b0});
                end
                acc_bits = '0;
                acc_cnt  = 0;
                flag_tail(1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_in || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return LEN_W'($urandom_range(1, 10));
        if (roll < 95) return LEN_W'($urandom_range(11, 32));
        return LEN_W'($urandom_range(0, 63));
    endfunction

    // drive one word, predict on acceptance, then leave a random gap; ends on a falling edge
    task automatic send_word(input t_word w, input int nexp, input t_byte typed);
        int gap;
        word_ch.valid       <= 1'b1;
        word_ch.action      <= w.action;
        word_ch.symbol      <= w.symbol;
        word_ch.code_bits   <= w.code_bits;
        word_ch.code_length <= w.code_length;
        do @(posedge i_clk); while (word_ch.ready !== 1'b1);
        @(negedge i_clk);
        predict_bytes(w);
        if (nexp == USE_MODEL) begin
            foreach (fresh_bytes[i]) want_bytes.push_back(fresh_bytes[i]);
        end else if (nexp == 1) begin
            want_bytes.push_back(typed);
        end
        gap = pick_gap();
        if (gap > 0) begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic put_rand(input t_word w);
        send_word(w, USE_MODEL, NO_BYTE);
        if (!(w.action == ACT_UNDEF || (w.action == ACT_LOAD && w.symbol >= SYMBOLS)))
            counted++;
    endtask

    task automatic hold_until_drained();
        word_ch.valid <= 1'b0;
        while (want_bytes.size() != 0) @(negedge i_clk);
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("%s", what);
    endtask

    always @(negedge i_clk) begin : rx_pace
        int roll;
        if ($urandom_range(0, 199) == 0) calm_out <= !calm_out;
        if (stall_left > 0) begin
            rx_ready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm_out) begin
            rx_ready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                rx_ready <= 1'b1;
            end else if (roll < 94) begin
                rx_ready   <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                rx_ready   <= 1'b0;
                stall_left <= $urandom_range(8, 30);
            end
        end
    end

    always @(posedge i_clk) begin : byte_check
        t_byte got;
        t_byte want;
        if (i_rst_n && byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
            got = '{byte_ch.out_byte, byte_ch.last, byte_ch.stream_end};
            if (want_bytes.size() == 0) begin
                flag_mismatch($sformatf("unexpected byte %02h last %0b end %0b",
                                        got.out_byte, got.last, got.stream_end));
            end else begin
                want = want_bytes.pop_front();
                if (got.out_byte !== want.out_byte || got.last !== want.last ||
                    got.stream_end !== want.stream_end)
                    flag_mismatch($sformatf(
                        "byte mismatch: expected %02h last %0b end %0b, got %02h last %0b end %0b",
                        want.out_byte, want.last, want.stream_end,
                        got.out_byte, got.last, got.stream_end));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** huffman_stream_encoder: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        logic [SYM_W-1:0] pool [12];
        int nsym;
        int nenc;
        int roll;
        int stream;
        word_ch.valid       = 1'b0;
        word_ch.action      = ACT_LOAD;
        word_ch.symbol      = '0;
        word_ch.code_bits   = '0;
        word_ch.code_length = '0;
        for (int i = 0; i < SYMBOLS; i++) begin
            code_of[i] = '0;
            len_of[i]  = '0;
        end
        acc_bits = '0;
        acc_cnt  = 0;
        stream   = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].nexp, dir_rows[i].r);

        // random code streams: load a small alphabet, encode mostly from it, mostly finish
        while (counted < RAND_ITEMS) begin
            calm_in = ($urandom_range(0, 4) == 0);
            if (stream == 0 || $urandom_range(0, 3) == 0) hold_until_drained();
            nsym = $urandom_range(2, 12);
            for (int i = 0; i < nsym; i++) begin
                pool[i] = SYM_W'($urandom_range(0, 255));
                put_rand(make_word(ACT_LOAD, pool[i], $urandom, rand_len()));
            end
            if ($urandom_range(0, 99) < 85)
                put_rand(make_word(ACT_LOAD, SYM_W'(END_SYMBOL), $urandom, rand_len()));
            nenc = $urandom_range(3, 25);
            for (int i = 0; i < nenc; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 82)
                    put_rand(make_word(ACT_ENCODE, pool[$urandom_range(0, nsym - 1)],
                                       $urandom, LEN_W'($urandom)));
                else if (roll < 90)
                    put_rand(make_word(ACT_ENCODE, SYM_W'($urandom_range(0, 255)),
                                       $urandom, LEN_W'($urandom)));
                else if (roll < 94)
                    put_rand(make_word(ACT_ENCODE,
                                       SYM_W'($urandom_range(END_SYMBOL, 2**SYM_W - 1)),
                                       $urandom, LEN_W'($urandom)));
                else if (roll < 97)
                    put_rand(make_word(ACT_LOAD, SYM_W'($urandom_range(0, 2**SYM_W - 1)),
                                       $urandom, rand_len()));
                else
                    put_rand(make_word(ACT_UNDEF, SYM_W'($urandom), $urandom,
                                       LEN_W'($urandom)));
            end
            // now and then a stream runs on into the next one without a finish
            if ($urandom_range(0, 9) != 0)
                put_rand(make_word(ACT_FINISH, SYM_W'($urandom), $urandom,
                                   LEN_W'($urandom)));
            stream++;
        end

        word_ch.valid <= 1'b0;
        while (want_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && want_bytes.size() == 0)
            $display("** huffman_stream_encoder: PASSED **");
        else
            $display("** huffman_stream_encoder: FAILED **");
        $finish;
    end

endmodule
